// File: rtl/core/dstp_pkg.sv
// Package for the data size text parser: parse phase codes, character codes and prefix shift amounts.
// No dependencies; used by every file of the parser.
`timescale 1ns / 1ps
`default_nettype none
package dstp_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned SizeW  = 64;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned ShiftW = 6;

	typedef logic [CharW-1:0]  char_t;
	typedef logic [SizeW-1:0]  size_t;
	typedef logic [PhaseW-1:0] phase_t;
	typedef logic [ShiftW-1:0] shift_t;

	localparam phase_t PH_LEAD   = 3'd0;
	localparam phase_t PH_DIGITS = 3'd1;
	localparam phase_t PH_GAP    = 3'd2;
	localparam phase_t PH_PREFIX = 3'd3;
	localparam phase_t PH_I      = 3'd4;
	localparam phase_t PH_TRAIL  = 3'd5;
	localparam phase_t PH_ERROR  = 3'd6;

	localparam char_t CH_NUL   = 8'h00;
	localparam char_t CH_TAB   = 8'h09;
	localparam char_t CH_SPACE = 8'h20;
	localparam char_t CH_ZERO  = 8'h30;
	localparam char_t CH_NINE  = 8'h39;
	localparam char_t CH_UC_B  = 8'h42;
	localparam char_t CH_LC_B  = 8'h62;
	localparam char_t CH_UC_I  = 8'h49;
	localparam char_t CH_LC_I  = 8'h69;
	localparam char_t CH_UC_K  = 8'h4B;
	localparam char_t CH_LC_K  = 8'h6B;
	localparam char_t CH_UC_M  = 8'h4D;
	localparam char_t CH_LC_M  = 8'h6D;
	localparam char_t CH_UC_G  = 8'h47;
	localparam char_t CH_LC_G  = 8'h67;
	localparam char_t CH_UC_T  = 8'h54;
	localparam char_t CH_LC_T  = 8'h74;

	localparam shift_t SH_NONE = 6'd0;
	localparam shift_t SH_KILO = 6'd10;
	localparam shift_t SH_MEGA = 6'd20;
	localparam shift_t SH_GIGA = 6'd30;
	localparam shift_t SH_TERA = 6'd40;

endpackage
`default_nettype wire

// File: rtl/core/dstp_char_if.sv
// Character stream channel: valid/ready handshake carrying one text byte.
// Depends on dstp_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none
interface dstp_char_if;
	logic              valid;
	logic              ready;
	dstp_pkg::char_t   char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dstp_size_if.sv
// Result channel: valid/ready handshake carrying the accept flag and byte count.
// Depends on dstp_pkg for the payload type.
`timescale 1ns / 1ps
`default_nettype none
interface dstp_size_if;
	logic              valid;
	logic              ready;
	logic              accepted;
	dstp_pkg::size_t   size_bytes;

	modport source (output valid, output accepted, output size_bytes, input ready);
	modport sink   (input valid, input accepted, input size_bytes, output ready);
endinterface
`default_nettype wire

// File: rtl/core/data_size_text_parser_core.sv
// A terminator passes from the input register into the result register.
// Throughput: one character per cycle, but for the input stall below; the digit step (x*10 + d with carry-out
// check) is combinational and feeds the accumulator register directly.
// The input stage stalls only while it holds a terminator and the result
// register is full and not taken. Reset clears all parse state and valid flags.
// Depends on dstp_pkg, dstp_char_if and dstp_size_if.
`timescale 1ns / 1ps
`default_nettype none
module data_size_text_parser_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	dstp_char_if.sink         text,
	dstp_size_if.source       result
);

	// input register
	logic             valid_s1;
	dstp_pkg::char_t  char_s1;

	// parse state
	dstp_pkg::phase_t phase_q;
	dstp_pkg::size_t  number_q;
	dstp_pkg::shift_t shift_q;

	// result register
	logic             out_valid_q;
	logic             accepted_q;
	dstp_pkg::size_t  size_q;

	logic advance;
	logic work;
	logic is_term;

	assign is_term = (char_s1 == dstp_pkg::CH_NUL);
	assign advance = !(valid_s1 && is_term && out_valid_q && !result.ready);
	assign work    = valid_s1 && advance;

	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			char_s1 <= text.char_code;
		end
	end

	// character classes
	logic             is_digit;
	logic             is_blank;
	logic             is_b;
	logic             is_i;
	logic [3:0]       digit;
	dstp_pkg::shift_t prefix_sh;

	assign is_digit = (char_s1 >= dstp_pkg::CH_ZERO) && (char_s1 <= dstp_pkg::CH_NINE);
	assign is_blank = (char_s1 == dstp_pkg::CH_SPACE) || (char_s1 == dstp_pkg::CH_TAB);
	assign is_b     = (char_s1 == dstp_pkg::CH_UC_B) || (char_s1 == dstp_pkg::CH_LC_B);
	assign is_i     = (char_s1 == dstp_pkg::CH_UC_I) || (char_s1 == dstp_pkg::CH_LC_I);
	assign digit    = char_s1[3:0];

	always_comb begin
		case (char_s1)
			dstp_pkg::CH_UC_K, dstp_pkg::CH_LC_K: prefix_sh = dstp_pkg::SH_KILO;
			dstp_pkg::CH_UC_M, dstp_pkg::CH_LC_M: prefix_sh = dstp_pkg::SH_MEGA;
			dstp_pkg::CH_UC_G, dstp_pkg::CH_LC_G: prefix_sh = dstp_pkg::SH_GIGA;
			dstp_pkg::CH_UC_T, dstp_pkg::CH_LC_T: prefix_sh = dstp_pkg::SH_TERA;
			default:                              prefix_sh = dstp_pkg::SH_NONE;
		endcase
	end

	// x*10 + d as (x<<3) + (x<<1) + d; any bit above 63 is an overflow
	logic [dstp_pkg::SizeW+3:0] acc_next;
	logic                       acc_ovf;

	assign acc_next = {1'b0, number_q, 3'b000} + {3'b000, number_q, 1'b0}
		+ {{(dstp_pkg::SizeW){1'b0}}, digit};
	assign acc_ovf  = |acc_next[dstp_pkg::SizeW+3:dstp_pkg::SizeW];

	// scaling at the terminator: bits shifted out must all be zero
	logic scale_ovf;

	always_comb begin
		case (shift_q)
			dstp_pkg::SH_KILO: scale_ovf = |number_q[63:54];
			dstp_pkg::SH_MEGA: scale_ovf = |number_q[63:44];
			dstp_pkg::SH_GIGA: scale_ovf = |number_q[63:34];
			dstp_pkg::SH_TERA: scale_ovf = |number_q[63:24];
			default:           scale_ovf = 1'b0;
		endcase
	end

	logic            term_ok;
	dstp_pkg::size_t scaled;

	assign scaled  = number_q << shift_q;
	assign term_ok = ((phase_q == dstp_pkg::PH_DIGITS) || (phase_q == dstp_pkg::PH_GAP)
		|| (phase_q == dstp_pkg::PH_PREFIX) || (phase_q == dstp_pkg::PH_TRAIL))
		&& !scale_ovf;

	// next state for a non-terminator character
	dstp_pkg::phase_t phase_d;
	dstp_pkg::size_t  number_d;
	dstp_pkg::shift_t shift_d;
	logic             unit_lead;

	always_comb begin
		phase_d   = phase_q;
		number_d  = number_q;
		shift_d   = shift_q;
		unit_lead = 1'b0;
		case (phase_q)
			dstp_pkg::PH_LEAD: begin
				if (is_digit) begin
					number_d = {{(dstp_pkg::SizeW-4){1'b0}}, digit};
					phase_d  = dstp_pkg::PH_DIGITS;
				end else if (!is_blank) begin
					phase_d = dstp_pkg::PH_ERROR;
				end
			end
			dstp_pkg::PH_DIGITS: begin
				if (is_digit) begin
					if (acc_ovf) begin
						phase_d = dstp_pkg::PH_ERROR;
					end else begin
						number_d = acc_next[dstp_pkg::SizeW-1:0];
					end
				end else if (is_blank) begin
					phase_d = dstp_pkg::PH_GAP;
				end else begin
					unit_lead = 1'b1;
				end
			end
			dstp_pkg::PH_GAP: begin
				unit_lead = !is_blank;
			end
			dstp_pkg::PH_PREFIX: begin
				if (is_i) begin
					phase_d = dstp_pkg::PH_I;
				end else if (is_b || is_blank) begin
					phase_d = dstp_pkg::PH_TRAIL;
				end else begin
					phase_d = dstp_pkg::PH_ERROR;
				end
			end
			dstp_pkg::PH_I: begin
				phase_d = is_b ? dstp_pkg::PH_TRAIL : dstp_pkg::PH_ERROR;
			end
			dstp_pkg::PH_TRAIL: begin
				if (!is_blank) begin
					phase_d = dstp_pkg::PH_ERROR;
				end
			end
			default: begin
				phase_d = dstp_pkg::PH_ERROR;
			end
		endcase
		if (unit_lead) begin
			if (prefix_sh != dstp_pkg::SH_NONE) begin
				shift_d = prefix_sh;
				phase_d = dstp_pkg::PH_PREFIX;
			end else if (is_b) begin
				shift_d = dstp_pkg::SH_NONE;
				phase_d = dstp_pkg::PH_TRAIL;
			end else begin
				phase_d = dstp_pkg::PH_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= dstp_pkg::PH_LEAD;
			number_q <= '0;
			shift_q  <= dstp_pkg::SH_NONE;
		end else if (work) begin
			if (is_term) begin
				phase_q  <= dstp_pkg::PH_LEAD;
				number_q <= '0;
				shift_q  <= dstp_pkg::SH_NONE;
			end else begin
				phase_q  <= phase_d;
				number_q <= number_d;
				shift_q  <= shift_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (work && is_term) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (work && is_term) begin
			accepted_q <= term_ok;
			size_q     <= term_ok ? scaled : '0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.accepted   = accepted_q;
	assign result.size_bytes = size_q;

`ifndef SYNTHESIS
	// a new result appears only after a terminator was processed
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(work && is_term))
		else $error("result valid without a terminator");

	// a rejected string reports a zero size
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !accepted_q |-> size_q == '0)
		else $error("rejected result with nonzero size");

	// the terminator returns the parser to its reset state
	assert property (@(posedge clk) disable iff (!arst_n)
		work && is_term |=> phase_q == dstp_pkg::PH_LEAD && number_q == '0
			&& shift_q == dstp_pkg::SH_NONE)
		else $error("parse state not cleared after terminator");

	// the input stalls only behind a pending terminator and a full result register
	assert property (@(posedge clk) disable iff (!arst_n)
		!text.ready |-> valid_s1 && is_term && out_valid_q && !result.ready)
		else $error("input stalled without cause");

	// a pending result that is not taken must not be overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |=> $stable(size_q) && $stable(accepted_q))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
